// ===== sv/imu_complementary_filter_top_assert.svh =====
// Assertion macros for the complementary filter top level.
// Relies on i_clk and i_rst_n being visible where the macros are used.
`ifndef IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IMU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/imu_cf_pkg.sv =====
// Shared types, widths and constants of the IMU complementary filter.
// Used by the MAC unit, the CORDIC unit and the top level; no dependencies.
`default_nettype none

package imu_cf_pkg;

    localparam int IN_W    = 16;
    localparam int ANG_W   = 32;
    localparam int PATH_W  = 33;
    localparam int ALPHA_W = 17;
    localparam int DT_W    = 24;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 33;
    localparam int ACC_W   = 52;
    localparam int CW      = 27;
    localparam int CIN_W   = 17;
    localparam int PRE_SHIFT   = 8;
    localparam int INCR_SHIFT  = 8;
    localparam int BLEND_SHIFT = 16;
    localparam int ATAN_DEPTH  = 24;
    localparam int ATAN_IDX_W  = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd58982;
    localparam logic [DT_W-1:0]    PERIOD_RESET = 24'd83886;

    localparam logic signed [CW-1:0] Z_HALF_TURN = 27'sd11796480;

    localparam logic [1:0] AX_ROLL  = 2'd0;
    localparam logic [1:0] AX_PITCH = 2'd1;
    localparam logic [1:0] AX_YAW   = 2'd2;

    typedef struct packed {
        logic                      en;
        logic                      clr;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mac_op;

    // atan(2^-i) in degrees, Q16.16, rounded to nearest.
    function automatic logic signed [CW-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/imu_cf_mac.sv =====
// Shared signed multiply-accumulate unit of the complementary filter.
// Depends on imu_cf_pkg for the operation struct and widths.
`default_nettype none

module imu_cf_mac (
    input  wire logic                                    i_clk,
    input  wire imu_cf_pkg::t_mac_op                     i_op,
    output logic signed [imu_cf_pkg::ACC_W-1:0]          o_acc
);

    localparam int PROD_W = imu_cf_pkg::MUL_A_W + imu_cf_pkg::MUL_B_W;

    logic signed [PROD_W-1:0]            w_prod;
    logic signed [imu_cf_pkg::ACC_W-1:0] r_acc;

    assign w_prod = $signed(i_op.a) * $signed(i_op.b);

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= (i_op.clr ? '0 : r_acc) + w_prod[imu_cf_pkg::ACC_W-1:0];
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== sv/imu_cf_cordic.sv =====
// Iterative vectoring CORDIC that returns atan2(y, x) in Q16.16 degrees.
// Depends on imu_cf_pkg for widths and the arctangent table.
`default_nettype none

module imu_cf_cordic #(
    parameter int ITERATIONS = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic signed [imu_cf_pkg::CIN_W-1:0]     i_y,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_x,
    output logic                                         o_done,
    output logic signed [imu_cf_pkg::CW-1:0]             o_angle
);

    localparam int CW = imu_cf_pkg::CW;
    localparam logic [imu_cf_pkg::ATAN_IDX_W-1:0] LAST_IT =
        imu_cf_pkg::ATAN_IDX_W'(ITERATIONS - 1);

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_RUN  = 2'b10
    } t_cstate;

    t_cstate r_state;
    logic [imu_cf_pkg::ATAN_IDX_W-1:0] r_cnt;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic                 r_zero;
    logic                 r_done;

    logic signed [CW-1:0] w_x0;
    logic signed [CW-1:0] w_y0;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [CW-1:0] w_tab;

    assign w_x0  = CW'(i_x) <<< imu_cf_pkg::PRE_SHIFT;
    assign w_y0  = CW'(i_y) <<< imu_cf_pkg::PRE_SHIFT;
    assign w_xs  = r_x >>> r_cnt;
    assign w_ys  = r_y >>> r_cnt;
    assign w_tab = imu_cf_pkg::atan_deg(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_RUN;
                        r_cnt   <= '0;
                    end
                end
                C_RUN: begin
                    if (r_cnt == LAST_IT) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == C_IDLE) && i_start) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (w_x0 < 0) begin
                // A vector in the left half plane is turned by a half turn first.
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= (w_y0 >= 0) ? imu_cf_pkg::Z_HALF_TURN : -imu_cf_pkg::Z_HALF_TURN;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_state == C_RUN) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_tab;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_tab;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : r_z;

endmodule

`default_nettype wire

// ===== sv/imu_complementary_filter_top.sv =====
// Each accepted request runs two serial CORDIC passes and nine MAC steps, and its result is
// posted once the output register is free. The next request is taken only once the block is
// idle again, even while the previous result still waits.
// Reset (synchronous, active low) clears the angles to zero and loads the default
// alpha and sample period.
`default_nettype none
`include "imu_complementary_filter_top_assert.svh"

module imu_complementary_filter_top #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [imu_cf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [imu_cf_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_accel_x,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_accel_y,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_accel_z,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_gyro_x,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_gyro_y,
    input  wire logic signed [imu_cf_pkg::IN_W-1:0]      i_gyro_z,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic signed [imu_cf_pkg::ANG_W-1:0]          o_roll_out,
    output logic signed [imu_cf_pkg::ANG_W-1:0]          o_pitch_out,
    output logic signed [imu_cf_pkg::ANG_W-1:0]          o_yaw_out
);

    localparam int ANG_W  = imu_cf_pkg::ANG_W;
    localparam int PATH_W = imu_cf_pkg::PATH_W;
    localparam int ACC_W  = imu_cf_pkg::ACC_W;
    localparam int CW     = imu_cf_pkg::CW;
    localparam int SH_W   = ACC_W - imu_cf_pkg::BLEND_SHIFT;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_INCR   = 9'b000000010,
        S_ADD    = 9'b000000100,
        S_CSTART = 9'b000001000,
        S_CWAIT  = 9'b000010000,
        S_BL1    = 9'b000100000,
        S_BL2    = 9'b001000000,
        S_SAT    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [1:0] r_idx;
    logic       r_cidx;
    logic [imu_cf_pkg::ALPHA_W-1:0] r_alpha;
    logic [imu_cf_pkg::DT_W-1:0]    r_period;
    logic [imu_cf_pkg::ALPHA_W-1:0] r_a;
    logic [imu_cf_pkg::DT_W-1:0]    r_dt;
    logic signed [imu_cf_pkg::IN_W-1:0] r_ax;
    logic signed [imu_cf_pkg::IN_W-1:0] r_ay;
    logic signed [imu_cf_pkg::IN_W-1:0] r_az;
    logic signed [imu_cf_pkg::IN_W-1:0] r_gyro [3];
    logic signed [ANG_W-1:0]  r_angle [3];
    logic signed [PATH_W-1:0] r_path [3];
    logic signed [CW-1:0]     r_tilt [2];
    logic                     r_out_valid;
    logic signed [ANG_W-1:0]  r_roll_out;
    logic signed [ANG_W-1:0]  r_pitch_out;
    logic signed [ANG_W-1:0]  r_yaw_out;

    imu_cf_pkg::t_mac_op w_op;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [PATH_W-1:0] w_incr;
    logic signed [SH_W-1:0]   w_sh;
    logic signed [ANG_W-1:0]  w_sat;
    logic signed [CW-1:0]     w_tilt_sel;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_cord_start;
    logic                     w_cord_done;
    logic signed [imu_cf_pkg::CIN_W-1:0] w_cord_y;
    logic signed [CW-1:0]     w_cord_angle;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    imu_cf_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_acc (w_acc)
    );

    // Pass zero (r_cidx low) computes the roll tilt, pass one the pitch tilt.
    assign w_cord_start = (r_state == S_CSTART);
    assign w_cord_y     = r_cidx ? -imu_cf_pkg::CIN_W'(r_ax) : imu_cf_pkg::CIN_W'(r_ay);

    imu_cf_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_y     (w_cord_y),
        .i_x     (r_az),
        .o_done  (w_cord_done),
        .o_angle (w_cord_angle)
    );

    assign w_incr = w_acc[imu_cf_pkg::INCR_SHIFT+PATH_W-1:imu_cf_pkg::INCR_SHIFT];
    assign w_sh   = w_acc[ACC_W-1:imu_cf_pkg::BLEND_SHIFT];

    always_comb begin
        if (w_sh > SH_W'(33'sh07FFFFFFF)) begin
            w_sat = {1'b0, {(ANG_W-1){1'b1}}};
        end else if (w_sh < -SH_W'(33'sh080000000)) begin
            w_sat = {1'b1, {(ANG_W-1){1'b0}}};
        end else begin
            w_sat = w_sh[ANG_W-1:0];
        end
    end

    assign w_tilt_sel = (r_idx == imu_cf_pkg::AX_YAW) ? '0 : r_tilt[r_idx[0]];

    always_comb begin
        w_op.en  = 1'b0;
        w_op.clr = 1'b0;
        w_op.a   = '0;
        w_op.b   = '0;
        case (r_state)
            S_INCR: begin
                w_op.en  = 1'b1;
                w_op.clr = 1'b1;
                w_op.a   = imu_cf_pkg::MUL_A_W'(r_dt);
                w_op.b   = imu_cf_pkg::MUL_B_W'(r_gyro[r_idx]);
            end
            S_BL1: begin
                w_op.en  = 1'b1;
                w_op.clr = 1'b1;
                w_op.a   = imu_cf_pkg::MUL_A_W'(r_a);
                w_op.b   = r_path[r_idx];
            end
            S_BL2: begin
                w_op.en  = 1'b1;
                w_op.a   = imu_cf_pkg::MUL_A_W'(imu_cf_pkg::ALPHA_ONE - r_a);
                w_op.b   = imu_cf_pkg::MUL_B_W'(w_tilt_sel);
            end
            default: begin
                w_op.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_INCR;
                end
            end
            S_INCR: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = (r_idx == imu_cf_pkg::AX_YAW) ? S_CSTART : S_INCR;
            end
            S_CSTART: begin
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (w_cord_done) begin
                    n_state = r_cidx ? S_BL1 : S_CSTART;
                end
            end
            S_BL1: begin
                n_state = S_BL2;
            end
            S_BL2: begin
                n_state = S_SAT;
            end
            S_SAT: begin
                n_state = (r_idx == imu_cf_pkg::AX_YAW) ? S_DONE : S_BL1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cidx      <= 1'b0;
            r_alpha     <= imu_cf_pkg::ALPHA_RESET;
            r_period    <= imu_cf_pkg::PERIOD_RESET;
            r_out_valid <= 1'b0;
            r_angle[0]  <= '0;
            r_angle[1]  <= '0;
            r_angle[2]  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    imu_cf_pkg::REG_ALPHA:  r_alpha  <= i_cfg_wdata[imu_cf_pkg::ALPHA_W-1:0];
                    imu_cf_pkg::REG_PERIOD: r_period <= i_cfg_wdata[imu_cf_pkg::DT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_idx  <= imu_cf_pkg::AX_ROLL;
                r_cidx <= 1'b0;
            end
            if ((r_state == S_ADD) || (r_state == S_SAT)) begin
                r_idx <= (r_idx == imu_cf_pkg::AX_YAW) ? imu_cf_pkg::AX_ROLL : r_idx + 2'd1;
            end
            if ((r_state == S_CWAIT) && w_cord_done) begin
                r_cidx <= 1'b1;
            end
            if (r_state == S_SAT) begin
                r_angle[r_idx] <= w_sat;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax    <= i_accel_x;
            r_ay    <= i_accel_y;
            r_az    <= i_accel_z;
            r_gyro[0] <= i_gyro_x;
            r_gyro[1] <= i_gyro_y;
            r_gyro[2] <= i_gyro_z;
            r_a     <= (r_alpha > imu_cf_pkg::ALPHA_ONE) ? imu_cf_pkg::ALPHA_ONE : r_alpha;
            r_dt    <= r_period;
        end
        if (r_state == S_ADD) begin
            r_path[r_idx] <= PATH_W'(r_angle[r_idx]) + w_incr;
        end
        if ((r_state == S_CWAIT) && w_cord_done) begin
            r_tilt[r_cidx] <= w_cord_angle;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_roll_out  <= r_angle[0];
            r_pitch_out <= r_angle[1];
            r_yaw_out   <= r_angle[2];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_roll_out  = r_roll_out;
    assign o_pitch_out = r_pitch_out;
    assign o_yaw_out   = r_yaw_out;

    `IMU_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_in_ready,
        "Block still ready right after taking a request.")
    `IMU_ASSERT_IMP(a_cordic_done_in_wait, w_cord_done, r_state == S_CWAIT,
        "CORDIC finished while the sequencer was not waiting for it.")
    `IMU_ASSERT_NEXT(a_result_posted, (r_state == S_DONE) && w_out_free,
        r_out_valid && (r_state == S_IDLE), "Finished result was not posted.")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for imu_complementary_filter_top: random six-axis samples
// with random handshake stalls, checked against a built-in fixed-point attitude predictor.
// Depends on imu_cf_pkg and the filter RTL only.

module tb;

    localparam int     IN_W              = imu_cf_pkg::IN_W;
    localparam int     ANG_W             = imu_cf_pkg::ANG_W;
    localparam int     ALPHA_W           = imu_cf_pkg::ALPHA_W;
    localparam int     DT_W              = imu_cf_pkg::DT_W;
    localparam int     CFG_IDX_W         = imu_cf_pkg::CFG_IDX_W;
    localparam int     CFG_W             = imu_cf_pkg::CFG_W;
    localparam int     INCR_SHIFT        = imu_cf_pkg::INCR_SHIFT;
    localparam int     BLEND_SHIFT       = imu_cf_pkg::BLEND_SHIFT;
    localparam int     CORDIC_ITERATIONS = 16;
    localparam int     CORDIC_STEPS      = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam longint FULL_WEIGHT       = 65536;
    localparam longint HALF_TURN_Q16     = 180 * 65536;
    localparam int     N_PHASES          = 10;
    localparam int     ITEMS_PER_PHASE   = 150;
    localparam int     SETTLE_CYCLES     = 64;
    localparam int     WATCHDOG_LIMIT    = 2000;

    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] az;
        logic signed [IN_W-1:0] gx;
        logic signed [IN_W-1:0] gy;
        logic signed [IN_W-1:0] gz;
    } t_imu_sample;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
    } t_angles;

    class attitude_board;
        t_angles                 pending_angles[$];
        int                      mismatches;
        logic signed [ANG_W-1:0] roll_q;
        logic signed [ANG_W-1:0] pitch_q;
        logic signed [ANG_W-1:0] yaw_q;
        logic [ALPHA_W-1:0]      alpha_q;
        logic [DT_W-1:0]         period_q;

        function new();
            roll_q     = '0;
            pitch_q    = '0;
            yaw_q      = '0;
            alpha_q    = 17'd58982;
            period_q   = 24'd83886;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                imu_cf_pkg::REG_ALPHA:  alpha_q = data[ALPHA_W-1:0];
                imu_cf_pkg::REG_PERIOD: period_q = data[DT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [ANG_W-1:0] clamp32(longint v);
            if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
            if (v < -longint'(32'sh7FFFFFFF) - 1) return 32'sh80000000;
            return v[ANG_W-1:0];
        endfunction

        // Vectoring CORDIC atan2 in Q16.16 degrees.
        function longint tilt_deg(longint y, longint x);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 256;
            y = y * 256;
            if (x < 0) begin
                z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q16[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q16[i];
                end
            end
            return z;
        endfunction

        function void note_sample(t_imu_sample s);
            longint  dt;
            longint  a;
            longint  roll_g;
            longint  pitch_g;
            longint  yaw_g;
            longint  roll_t;
            longint  pitch_t;
            t_angles e;
            dt      = longint'(period_q);
            a       = (alpha_q > FULL_WEIGHT) ? FULL_WEIGHT : longint'(alpha_q);
            roll_g  = longint'(roll_q) + ((longint'(s.gx) * dt) >>> INCR_SHIFT);
            pitch_g = longint'(pitch_q) + ((longint'(s.gy) * dt) >>> INCR_SHIFT);
            yaw_g   = longint'(yaw_q) + ((longint'(s.gz) * dt) >>> INCR_SHIFT);
            pitch_t = tilt_deg(-longint'(s.ax), longint'(s.az));
            roll_t  = tilt_deg(longint'(s.ay), longint'(s.az));
            roll_q  = clamp32((a * roll_g + (FULL_WEIGHT - a) * roll_t) >>> BLEND_SHIFT);
            pitch_q = clamp32((a * pitch_g + (FULL_WEIGHT - a) * pitch_t) >>> BLEND_SHIFT);
            yaw_q   = clamp32((a * yaw_g) >>> BLEND_SHIFT);
            e.roll  = roll_q;
            e.pitch = pitch_q;
            e.yaw   = yaw_q;
            pending_angles.push_back(e);
        endfunction

        function void compare_field(string name, logic signed [ANG_W-1:0] expected,
                                    logic signed [ANG_W-1:0] actual);
            if (actual !== expected) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, expected, actual);
            end
        endfunction

        function void check_angles(logic signed [ANG_W-1:0] roll,
                                   logic signed [ANG_W-1:0] pitch,
                                   logic signed [ANG_W-1:0] yaw);
            t_angles e;
            if (pending_angles.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request pending: roll %0d pitch %0d yaw %0d",
                         $time, roll, pitch, yaw);
                return;
            end
            e = pending_angles.pop_front();
            compare_field("roll", e.roll, roll);
            compare_field("pitch", e.pitch, pitch);
            compare_field("yaw", e.yaw, yaw);
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx   = '0;
    logic [CFG_W-1:0]           i_cfg_wdata = '0;
    logic                       i_in_valid  = 1'b0;
    logic signed [IN_W-1:0]     i_accel_x   = '0;
    logic signed [IN_W-1:0]     i_accel_y   = '0;
    logic signed [IN_W-1:0]     i_accel_z   = '0;
    logic signed [IN_W-1:0]     i_gyro_x    = '0;
    logic signed [IN_W-1:0]     i_gyro_y    = '0;
    logic signed [IN_W-1:0]     i_gyro_z    = '0;
    logic                       i_out_ready = 1'b0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [ANG_W-1:0]    o_roll_out;
    logic signed [ANG_W-1:0]    o_pitch_out;
    logic signed [ANG_W-1:0]    o_yaw_out;

    logic                       steady_mode = 1'b0;
    attitude_board              board;

    imu_complementary_filter_top #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_gyro_x    (i_gyro_x),
        .i_gyro_y    (i_gyro_y),
        .i_gyro_z    (i_gyro_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_roll_out  (o_roll_out),
        .o_pitch_out (o_pitch_out),
        .o_yaw_out   (o_yaw_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady_mode || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_angles(o_roll_out, o_pitch_out, o_yaw_out);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // All driving tasks are entered and left at a falling edge.
    task automatic send_sample(input t_imu_sample s);
        if (!steady_mode && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 64)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_x  <= s.ax;
        i_accel_y  <= s.ay;
        i_accel_z  <= s.az;
        i_gyro_x   <= s.gx;
        i_gyro_y   <= s.gy;
        i_gyro_z   <= s.gz;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic send_axes(input int ax, input int ay, input int az,
                             input int gx, input int gy, input int gz);
        t_imu_sample s;
        s.ax = ax[IN_W-1:0];
        s.ay = ay[IN_W-1:0];
        s.az = az[IN_W-1:0];
        s.gx = gx[IN_W-1:0];
        s.gy = gy[IN_W-1:0];
        s.gz = gz[IN_W-1:0];
        send_sample(s);
    endtask

    task automatic end_burst_and_drain();
        i_in_valid <= 1'b0;
        while (board.pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] alpha_data,
                                input logic [CFG_W-1:0] period_data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= imu_cf_pkg::REG_ALPHA;
        i_cfg_wdata <= alpha_data;
        @(negedge i_clk);
        board.set_reg(imu_cf_pkg::REG_ALPHA, alpha_data);
        i_cfg_idx   <= imu_cf_pkg::REG_PERIOD;
        i_cfg_wdata <= period_data;
        @(negedge i_clk);
        board.set_reg(imu_cf_pkg::REG_PERIOD, period_data);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [IN_W-1:0] pick_word(int kind, int span);
        logic signed [IN_W-1:0] corners [5];
        corners = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
        case (kind)
            0:       return IN_W'($urandom_range(0, 2 * span) - span);
            1:       return IN_W'($urandom);
            default: return corners[$urandom_range(0, 4)];
        endcase
    endfunction

    function automatic t_imu_sample random_sample();
        t_imu_sample s;
        int          roll_pick;
        int          kind;
        roll_pick = $urandom_range(99);
        kind = (roll_pick < 50) ? 0 : (roll_pick < 80) ? 1 : 2;
        s.ax = pick_word(kind, 20000);
        s.ay = pick_word(kind, 20000);
        s.az = pick_word(kind, 20000);
        s.gx = pick_word(kind, 2000);
        s.gy = pick_word(kind, 2000);
        s.gz = pick_word(kind, 2000);
        return s;
    endfunction

    initial begin
        logic [CFG_W-1:0] alpha_data;
        logic [CFG_W-1:0] period_data;
        board = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default settings: zero vectors, axis-aligned vectors and both half-turn cases.
        send_axes(0, 0, 0, 0, 0, 0);
        send_axes(0, 0, 16384, 0, 0, 0);
        send_axes(0, 32767, 0, 0, 0, 0);
        send_axes(32767, -32768, 0, 0, 0, 0);
        send_axes(0, 0, -32768, 0, 0, 0);
        send_axes(1, -1, -16384, 0, 0, 0);
        send_axes(-32768, 32767, 32767, 32767, -32768, 1);
        send_axes(-1, 1, -1, -32768, 32767, -32768);
        end_burst_and_drain();

        // Full gyro weight and longest period drive the angles into saturation.
        write_config(24'd65536, 24'hFFFFFF);
        repeat (4) send_axes(0, 0, 0, 32767, -32768, 32767);
        repeat (4) send_axes(0, 0, 0, -32768, 32767, -32768);
        end_burst_and_drain();

        // An alpha above one behaves as one.
        write_config(24'h01FFFF, 24'd1);
        send_axes(100, -200, 16000, 5, -5, 1000);
        send_axes(-16000, 16000, -100, -1, 1, -1);
        end_burst_and_drain();

        write_config(24'd0, 24'd0);
        send_axes(-32768, -32768, -32768, 32767, 32767, 32767);
        send_axes(32767, 32767, 32767, -32768, -32768, -32768);
        end_burst_and_drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            alpha_data = CFG_W'($urandom);
            case (ph % 5)
                0:       alpha_data[ALPHA_W-1:0] = 17'd65536;
                1:       alpha_data[ALPHA_W-1:0] = 17'd0;
                2:       alpha_data[ALPHA_W-1:0] = ALPHA_W'($urandom_range(65537, 131071));
                default: alpha_data[ALPHA_W-1:0] = ALPHA_W'($urandom_range(0, 65536));
            endcase
            case (ph % 4)
                0:       period_data = 24'hFFFFFF;
                1:       period_data = 24'd0;
                default: period_data = CFG_W'($urandom_range(0, 400000));
            endcase
            write_config(alpha_data, period_data);
            steady_mode = (ph == 5);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_sample(random_sample());
            end_burst_and_drain();
        end

        if (board.mismatches == 0 && board.pending_angles.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/imu_cf_pkg.sv
sv/imu_cf_mac.sv
sv/imu_cf_cordic.sv
sv/imu_complementary_filter_top.sv
dv/tb.sv
